@@ rtl/primitive_solid_voxel_classifier_macros.svh @@
// Assertion macros shared by the primitive solid voxel classifier RTL.
`ifndef PRIMITIVE_SOLID_VOXEL_CLASSIFIER_MACROS_SVH
`define PRIMITIVE_SOLID_VOXEL_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define PSVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Checks that the consequent holds in the cycle after the antecedent.
`define PSVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PSVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PSVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/psvc_pkg.sv @@
// Constants, widths and register codes of the primitive solid voxel classifier.
`default_nettype none

package psvc_pkg;

    // Number format of coordinates, axes and extents.
    localparam int COORD_WIDTH    = 21;
    localparam int FRAC_BITS      = 12;
    localparam int RADIUS_WIDTH   = 20;
    localparam int SPACING_WIDTH  = 20;
    localparam int KIND_WIDTH     = 2;
    localparam int PACKED_WIDTH   = 3 * COORD_WIDTH;

    localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 20'd4096;

    // Register port.
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_ADDR_WIDTH  = 6;
    localparam int CFG_IDX_LSB     = 3;
    localparam int CFG_INDEX_WIDTH = CFG_ADDR_WIDTH - CFG_IDX_LSB;

    // Stream words.
    localparam int IN_TDATA_WIDTH  = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = 8;

    // Datapath widths.
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int SQ_WIDTH   = 2 * DIFF_WIDTH;
    localparam int PROD_WIDTH = DIFF_WIDTH + COORD_WIDTH;
    localparam int DOT_WIDTH  = PROD_WIDTH + 2;
    localparam int MAG_WIDTH  = DOT_WIDTH - 1;
    localparam int DD_WIDTH   = SQ_WIDTH + 2;
    localparam int LO_WIDTH   = MAG_WIDTH / 2;
    localparam int HI_WIDTH   = MAG_WIDTH - LO_WIDTH;
    localparam int R2_WIDTH   = 2 * RADIUS_WIDTH;

    localparam int CYL_A      = R2_WIDTH + 2 * FRAC_BITS;
    localparam int CYL_B      = 2 * MAG_WIDTH;
    localparam int CYL_C      = DD_WIDTH + 2 * FRAC_BITS;
    localparam int CYL_AB     = (CYL_A > CYL_B) ? CYL_A : CYL_B;
    localparam int CYL_WIDTH  = ((CYL_AB > CYL_C) ? CYL_AB : CYL_C) + 1;

    localparam int HEXT_WIDTH = (COORD_WIDTH + 1 > SPACING_WIDTH) ? COORD_WIDTH + 1
                                                                   : SPACING_WIDTH;
    localparam int THR_WIDTH  = HEXT_WIDTH + FRAC_BITS;
    localparam int BOX_WIDTH  = (THR_WIDTH > MAG_WIDTH + 1) ? THR_WIDTH : MAG_WIDTH + 1;

    localparam int NUM_STAGES = 6;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;

    typedef enum logic [KIND_WIDTH-1:0] {
        SHAPE_SPHERE   = 2'd0,
        SHAPE_CYLINDER = 2'd1,
        SHAPE_BOX      = 2'd2
    } shape_kind_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SHAPE_KIND    = 3'd0,
        CFG_CENTER        = 3'd1,
        CFG_RADIUS        = 3'd2,
        CFG_AXIS_U        = 3'd3,
        CFG_AXIS_V        = 3'd4,
        CFG_AXIS_W        = 3'd5,
        CFG_HALF_EXTENTS  = 3'd6,
        CFG_CELL_SPACING  = 3'd7
    } cfg_index_t;

endpackage

`default_nettype wire

@@ rtl/primitive_solid_voxel_classifier.sv @@
// Streaming point-in-primitive classifier: sphere, infinite cylinder or oriented box.
//
// Usage: each word on the s_ channel is one grid cell center (x, y, z, signed
// fixed point); each word on the m_ channel is one solid flag for that point,
// in the same order. The primitive is set through the register port while no
// point is in flight.
// Path: an accepted point passes through the six register stages in order
// before its flag shows on m_tvalid.
// Throughput: one point per cycle while m_tready is high; the six register
// stages (difference, multiply, sum, compare and cylinder partial products,
// cylinder sum, output) each advance as soon as the stage after them has room.
// Reset: aresetn clears all valid bits and sets every configuration register to
// its reset value (cell spacing 1.0, all else zero); s_tready is high in the
// first cycle after reset.
// Stall: while m_tready is low the output word holds and the stages behind it
// fill up; s_tready drops only once all six stages hold a word.
`default_nettype none

`include "primitive_solid_voxel_classifier_macros.svh"

module primitive_solid_voxel_classifier
    import psvc_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    // Point stream. Fields from bit 0: point_x, point_y, point_z, zero fill.
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [IN_TDATA_WIDTH-1:0]   s_tdata,

    // Result stream. Fields from bit 0: solid, zero fill.
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [OUT_TDATA_WIDTH-1:0]       m_tdata,

    // Register port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [CFG_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [CFG_DATA_WIDTH-1:0]   pwdata,
    output logic [CFG_DATA_WIDTH-1:0]        prdata,
    output logic                             pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KIND_WIDTH-1:0]    kind_reg;
    logic [PACKED_WIDTH-1:0]  center_reg;
    logic [RADIUS_WIDTH-1:0]  radius_reg;
    logic [PACKED_WIDTH-1:0]  axis_reg [3];
    logic [PACKED_WIDTH-1:0]  hext_reg;
    logic [SPACING_WIDTH-1:0] spacing_reg;

    cfg_index_t cfg_idx;
    logic       cfg_we;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_index_t'(paddr[CFG_ADDR_WIDTH-1:CFG_IDX_LSB]);
    assign cfg_we  = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= '0;
            center_reg  <= '0;
            radius_reg  <= '0;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= '0;
            hext_reg    <= '0;
            spacing_reg <= SPACING_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_SHAPE_KIND:   kind_reg    <= pwdata[KIND_WIDTH-1:0];
                CFG_CENTER:       center_reg  <= pwdata[PACKED_WIDTH-1:0];
                CFG_RADIUS:       radius_reg  <= pwdata[RADIUS_WIDTH-1:0];
                CFG_AXIS_U:       axis_reg[0] <= pwdata[PACKED_WIDTH-1:0];
                CFG_AXIS_V:       axis_reg[1] <= pwdata[PACKED_WIDTH-1:0];
                CFG_AXIS_W:       axis_reg[2] <= pwdata[PACKED_WIDTH-1:0];
                CFG_HALF_EXTENTS: hext_reg    <= pwdata[PACKED_WIDTH-1:0];
                CFG_CELL_SPACING: spacing_reg <= pwdata[SPACING_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (cfg_idx)
            CFG_SHAPE_KIND:   prdata = CFG_DATA_WIDTH'(kind_reg);
            CFG_CENTER:       prdata = CFG_DATA_WIDTH'(center_reg);
            CFG_RADIUS:       prdata = CFG_DATA_WIDTH'(radius_reg);
            CFG_AXIS_U:       prdata = CFG_DATA_WIDTH'(axis_reg[0]);
            CFG_AXIS_V:       prdata = CFG_DATA_WIDTH'(axis_reg[1]);
            CFG_AXIS_W:       prdata = CFG_DATA_WIDTH'(axis_reg[2]);
            CFG_HALF_EXTENTS: prdata = CFG_DATA_WIDTH'(hext_reg);
            CFG_CELL_SPACING: prdata = CFG_DATA_WIDTH'(spacing_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Values derived from the configuration, refreshed every cycle
    // ------------------------------------------------------------------
    logic [R2_WIDTH-1:0]  r2_reg,  r2_next;
    logic [THR_WIDTH-1:0] thr_reg  [3];
    logic [THR_WIDTH-1:0] thr_next [3];

    // Radius squared and the box limits, max(2*h, spacing) scaled by 1.0.
    always_comb begin
        logic [HEXT_WIDTH-1:0] h2;
        logic [HEXT_WIDTH-1:0] sp;
        r2_next = R2_WIDTH'(radius_reg) * R2_WIDTH'(radius_reg);
        sp      = HEXT_WIDTH'(spacing_reg);
        for (int i = 0; i < 3; i++) begin
            h2          = HEXT_WIDTH'({hext_reg[i*COORD_WIDTH +: COORD_WIDTH], 1'b0});
            thr_next[i] = THR_WIDTH'((h2 < sp) ? sp : h2) << FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= r2_next;
        for (int i = 0; i < 3; i++) begin
            thr_reg[i] <= thr_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] adv;

    // A stage may load when it is empty or the stage after it loads too.
    always_comb begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // No word is taken while reset holds the valid bits clear.
    assign s_tready = aresetn && adv[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 0: offset from the center
    // ------------------------------------------------------------------
    diff_t d_reg  [3];
    diff_t d_next [3];

    always_comb begin
        coord_t pt;
        coord_t ct;
        for (int i = 0; i < 3; i++) begin
            pt        = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
            ct        = center_reg[i*COORD_WIDTH +: COORD_WIDTH];
            d_next[i] = {pt[COORD_WIDTH-1], pt} - {ct[COORD_WIDTH-1], ct};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= d_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares and axis products
    // ------------------------------------------------------------------
    logic signed [SQ_WIDTH-1:0]   sq_reg    [3];
    logic signed [SQ_WIDTH-1:0]   sq_next   [3];
    logic signed [PROD_WIDTH-1:0] prod_reg  [3][3];
    logic signed [PROD_WIDTH-1:0] prod_next [3][3];

    always_comb begin
        coord_t comp;
        for (int i = 0; i < 3; i++) begin
            sq_next[i] = d_reg[i] * d_reg[i];
            for (int a = 0; a < 3; a++) begin
                comp            = axis_reg[a][i*COORD_WIDTH +: COORD_WIDTH];
                prod_next[a][i] = d_reg[i] * comp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sq_reg   <= sq_next;
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared distance and projection magnitudes
    // ------------------------------------------------------------------
    logic [DD_WIDTH-1:0]  dd2_reg, dd2_next;
    logic [MAG_WIDTH-1:0] mag_reg  [3];
    logic [MAG_WIDTH-1:0] mag_next [3];

    always_comb begin
        logic signed [DOT_WIDTH-1:0] dot;
        dd2_next = DD_WIDTH'(unsigned'(sq_reg[0])) + DD_WIDTH'(unsigned'(sq_reg[1]))
                 + DD_WIDTH'(unsigned'(sq_reg[2]));
        for (int a = 0; a < 3; a++) begin
            dot = DOT_WIDTH'(prod_reg[a][0]) + DOT_WIDTH'(prod_reg[a][1])
                + DOT_WIDTH'(prod_reg[a][2]);
            if (dot < 0) begin
                dot = -dot;
            end
            mag_next[a] = dot[MAG_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            dd2_reg <= dd2_next;
            mag_reg <= mag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sphere and box tests, partial products of the cylinder term
    // ------------------------------------------------------------------
    logic                         sph3_reg, sph3_next;
    logic                         box3_reg, box3_next;
    logic [DD_WIDTH-1:0]          dd3_reg;
    logic [2*HI_WIDTH-1:0]        hh_reg, hh_next;
    logic [HI_WIDTH+LO_WIDTH-1:0] hl_reg, hl_next;
    logic [2*LO_WIDTH-1:0]        ll_reg, ll_next;

    always_comb begin
        logic [HI_WIDTH-1:0] hi;
        logic [LO_WIDTH-1:0] lo;
        sph3_next = CYL_WIDTH'(dd2_reg) <= CYL_WIDTH'(r2_reg);
        box3_next = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (BOX_WIDTH'({mag_reg[a], 1'b0}) > BOX_WIDTH'(thr_reg[a])) begin
                box3_next = 1'b0;
            end
        end
        // The projection on the cylinder axis is squared in halves.
        hi      = mag_reg[2][MAG_WIDTH-1:LO_WIDTH];
        lo      = mag_reg[2][LO_WIDTH-1:0];
        hh_next = (2*HI_WIDTH)'(hi) * (2*HI_WIDTH)'(hi);
        hl_next = (HI_WIDTH+LO_WIDTH)'(hi) * (HI_WIDTH+LO_WIDTH)'(lo);
        ll_next = (2*LO_WIDTH)'(lo) * (2*LO_WIDTH)'(lo);
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            sph3_reg <= sph3_next;
            box3_reg <= box3_next;
            dd3_reg  <= dd2_reg;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: both sides of the cylinder comparison, scaled by 1.0 squared
    // ------------------------------------------------------------------
    logic                 sph4_reg;
    logic                 box4_reg;
    logic [CYL_WIDTH-1:0] lhs_reg, lhs_next;
    logic [CYL_WIDTH-1:0] rhs_reg, rhs_next;

    always_comb begin
        lhs_next = CYL_WIDTH'(dd3_reg) << (2 * FRAC_BITS);
        rhs_next = (CYL_WIDTH'(hh_reg) << (2 * LO_WIDTH))
                 + (CYL_WIDTH'(hl_reg) << (LO_WIDTH + 1))
                 + CYL_WIDTH'(ll_reg)
                 + (CYL_WIDTH'(r2_reg) << (2 * FRAC_BITS));
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            sph4_reg <= sph3_reg;
            box4_reg <= box3_reg;
            lhs_reg  <= lhs_next;
            rhs_reg  <= rhs_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: pick the test of the configured shape into the output word
    // ------------------------------------------------------------------
    logic solid_reg, solid_next;

    always_comb begin
        case (kind_reg)
            SHAPE_SPHERE:   solid_next = sph4_reg;
            SHAPE_CYLINDER: solid_next = lhs_reg <= rhs_reg;
            SHAPE_BOX:      solid_next = box4_reg;
            default:        solid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            solid_reg <= solid_next;
        end
    end

    assign m_tdata = {{(OUT_TDATA_WIDTH-1){1'b0}}, solid_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Words in flight change only by what enters and what leaves.
    `PSVC_ASSERT_NEXT(a_occupancy, aclk, aresetn, aresetn, $countones(valid_reg) == $countones($past(valid_reg)) + int'($past(s_tvalid && s_tready)) - int'($past(m_tvalid && m_tready)))
    // A blocked first stage keeps its first and third offsets.
    `PSVC_ASSERT_NEXT(a_stage0_hold, aclk, aresetn, valid_reg[0] && !adv[0], valid_reg[0] && $stable(d_reg[0]) && $stable(d_reg[2]))
    // Input is refused only when every stage is full and the output stalls.
    `PSVC_ASSERT_IMPLIES(a_ready_full, aclk, aresetn, !s_tready, (&valid_reg) && !m_tready)
    // A stalled output keeps its flag.
    `PSVC_ASSERT_NEXT(a_out_hold, aclk, aresetn, valid_reg[NUM_STAGES-1] && !m_tready, $stable(solid_reg))

endmodule

`default_nettype wire
